/* sv/dpod_pkg.sv */
`default_nettype none

package dpod_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned SERIAL_W = 22;
    localparam int unsigned NUM_DATES = 4;

    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd12;

    // y / 100 == (y * 5243) >> 19, exact for any 14-bit y
    localparam int unsigned DIV100_MUL   = 5243;
    localparam int unsigned DIV100_SHIFT = 19;
    localparam int unsigned DIV100_W     = YEAR_W + 13;
    localparam int unsigned QUOT_W       = 8;
    localparam int unsigned CENTURY      = 100;
    localparam int unsigned YEAR_DAYS    = 365;
    localparam int unsigned Y365_W       = 23;
    localparam int unsigned MOFF_W       = 9;

    typedef struct packed {
        logic [YEAR_W-1:0]  a_start_year;
        logic [MONTH_W-1:0] a_start_month;
        logic [DAY_W-1:0]   a_start_day;
        logic [YEAR_W-1:0]  a_end_year;
        logic [MONTH_W-1:0] a_end_month;
        logic [DAY_W-1:0]   a_end_day;
        logic [YEAR_W-1:0]  b_start_year;
        logic [MONTH_W-1:0] b_start_month;
        logic [DAY_W-1:0]   b_start_day;
        logic [YEAR_W-1:0]  b_end_year;
        logic [MONTH_W-1:0] b_end_month;
        logic [DAY_W-1:0]   b_end_day;
    } in_t;

    typedef struct packed {
        logic [SERIAL_W-1:0] overlap_days;
        logic                periods_overlap;
        logic                date_error;
    } out_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    // days from 1 March to the first of month m, year taken as starting in March
    function automatic logic [MOFF_W-1:0] march_offset(input logic [MONTH_W-1:0] m);
        logic [MOFF_W-1:0] off;
        unique case (m)
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

/* sv/date_period_overlap_days.sv */
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  dpod_pkg::in_t  (two periods, four dates)
// out       output     out_valid/out_stall  dpod_pkg::out_t (count and flags)
// cfg       input      cfg_valid/cfg_ready  include_end_day (1 bit)
//
// Four register stages: constant products, date check and day serial,
// overlap bounds, count. One item per cycle while in_stall is low.
// Stages hold while the output is stalled and the stall ripples back to
// in_stall only when every stage is full. Reset clears the stage valids
// and sets include_end_day to 1.
`default_nettype none

module date_period_overlap_days (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire dpod_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output dpod_pkg::out_t      out_data,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic           cfg_data
);
    import dpod_pkg::*;

    logic ied_reg, ied_next;
    logic v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next, v4_reg, v4_next;
    logic adv1, adv2, adv3, adv4;

    logic [YEAR_W-1:0]  date_y [NUM_DATES];
    logic [MONTH_W-1:0] date_m [NUM_DATES];
    logic [DAY_W-1:0]   date_d [NUM_DATES];

    // stage 1
    logic [YEAR_W-1:0]  s1_y_reg    [NUM_DATES], s1_y_next    [NUM_DATES];
    logic [MONTH_W-1:0] s1_m_reg    [NUM_DATES], s1_m_next    [NUM_DATES];
    logic [DAY_W-1:0]   s1_d_reg    [NUM_DATES], s1_d_next    [NUM_DATES];
    logic [YEAR_W-1:0]  s1_yy_reg   [NUM_DATES], s1_yy_next   [NUM_DATES];
    logic [QUOT_W-1:0]  s1_qy_reg   [NUM_DATES], s1_qy_next   [NUM_DATES];
    logic [QUOT_W-1:0]  s1_qyy_reg  [NUM_DATES], s1_qyy_next  [NUM_DATES];
    logic [Y365_W-1:0]  s1_y365_reg [NUM_DATES], s1_y365_next [NUM_DATES];

    // stage 2
    logic [SERIAL_W-1:0] s2_serial_reg [NUM_DATES], s2_serial_next [NUM_DATES];
    logic [NUM_DATES-1:0] s2_ok_reg, s2_ok_next;

    // stage 3
    logic [SERIAL_W-1:0] s3_lo_reg, s3_lo_next, s3_hi_reg, s3_hi_next;
    logic s3_ovl_reg, s3_ovl_next, s3_err_reg, s3_err_next;

    // stage 4 (output register)
    out_t s4_reg, s4_next;

    assign cfg_ready = 1'b1;
    assign ied_next  = (cfg_valid && cfg_ready) ? cfg_data : ied_reg;

    assign adv4     = !v4_reg || !out_stall;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    assign v1_next = adv1 ? in_valid : v1_reg;
    assign v2_next = adv2 ? v1_reg   : v2_reg;
    assign v3_next = adv3 ? v2_reg   : v3_reg;
    assign v4_next = adv4 ? v3_reg   : v4_reg;

    assign date_y[0] = in_data.a_start_year;
    assign date_m[0] = in_data.a_start_month;
    assign date_d[0] = in_data.a_start_day;
    assign date_y[1] = in_data.a_end_year;
    assign date_m[1] = in_data.a_end_month;
    assign date_d[1] = in_data.a_end_day;
    assign date_y[2] = in_data.b_start_year;
    assign date_m[2] = in_data.b_start_month;
    assign date_d[2] = in_data.b_start_day;
    assign date_y[3] = in_data.b_end_year;
    assign date_m[3] = in_data.b_end_month;
    assign date_d[3] = in_data.b_end_day;

    for (genvar j = 0; j < NUM_DATES; j++) begin : g_date
        logic [DIV100_W-1:0] prod_y, prod_yy;
        logic                cent, leap;
        logic [DAY_W-1:0]    len;
        logic [SERIAL_W+1:0] sum;

        // stage 1: March-based year and the constant products
        always_comb
        begin
            s1_y_next[j]  = date_y[j];
            s1_m_next[j]  = date_m[j];
            s1_d_next[j]  = date_d[j];
            s1_yy_next[j] = (date_m[j] <= MONTH_FEB) ? date_y[j] - 14'd1 : date_y[j];
            prod_y        = DIV100_W'(date_y[j]) * DIV100_W'(DIV100_MUL);
            prod_yy       = DIV100_W'(s1_yy_next[j]) * DIV100_W'(DIV100_MUL);
            s1_qy_next[j]   = QUOT_W'(prod_y >> DIV100_SHIFT);
            s1_qyy_next[j]  = QUOT_W'(prod_yy >> DIV100_SHIFT);
            s1_y365_next[j] = Y365_W'(s1_yy_next[j]) * Y365_W'(YEAR_DAYS);
        end

        // stage 2: leap rule, range checks, day serial
        always_comb
        begin
            cent = ((YEAR_W+1)'(s1_qy_reg[j]) * (YEAR_W+1)'(CENTURY))
                   == (YEAR_W+1)'(s1_y_reg[j]);
            leap = cent ? (s1_qy_reg[j][1:0] == 2'd0) : (s1_y_reg[j][1:0] == 2'd0);
            len  = month_len(s1_m_reg[j], leap);
            s2_ok_next[j] = (s1_y_reg[j] != '0) && (s1_y_reg[j] <= YEAR_MAX)
                         && (s1_m_reg[j] != '0) && (s1_m_reg[j] <= MONTH_LAST)
                         && (s1_d_reg[j] != '0) && (s1_d_reg[j] <= len);
            sum = (SERIAL_W+2)'(s1_y365_reg[j])
                + (SERIAL_W+2)'(s1_yy_reg[j] >> 2)
                - (SERIAL_W+2)'(s1_qyy_reg[j])
                + (SERIAL_W+2)'(s1_qyy_reg[j] >> 2)
                + (SERIAL_W+2)'(march_offset(s1_m_reg[j]))
                + (SERIAL_W+2)'(s1_d_reg[j])
                - (SERIAL_W+2)'(1);
            s2_serial_next[j] = sum[SERIAL_W-1:0];
        end
    end

    // stage 3: later start, earlier end, overlap and error flags
    always_comb
    begin
        s3_lo_next  = (s2_serial_reg[0] > s2_serial_reg[2]) ? s2_serial_reg[0]
                                                              : s2_serial_reg[2];
        s3_hi_next  = (s2_serial_reg[1] < s2_serial_reg[3]) ? s2_serial_reg[1]
                                                              : s2_serial_reg[3];
        s3_ovl_next = !((s2_serial_reg[3] < s2_serial_reg[0])
                     || (s2_serial_reg[2] > s2_serial_reg[1]));
        s3_err_next = !(&s2_ok_reg);
    end

    // stage 4: count; a reversed period leaves only the end-day term
    always_comb
    begin
        logic [SERIAL_W-1:0] diff;
        diff = (s3_hi_reg > s3_lo_reg) ? s3_hi_reg - s3_lo_reg : '0;
        s4_next.periods_overlap = s3_ovl_reg && !s3_err_reg;
        s4_next.date_error      = s3_err_reg;
        s4_next.overlap_days    = s4_next.periods_overlap
                                ? diff + SERIAL_W'(ied_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ied_reg <= 1'b1;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
        end
        else
        begin
            ied_reg <= ied_next;
            v1_reg  <= v1_next;
            v2_reg  <= v2_next;
            v3_reg  <= v3_next;
            v4_reg  <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_y_reg    <= s1_y_next;
            s1_m_reg    <= s1_m_next;
            s1_d_reg    <= s1_d_next;
            s1_yy_reg   <= s1_yy_next;
            s1_qy_reg   <= s1_qy_next;
            s1_qyy_reg  <= s1_qyy_next;
            s1_y365_reg <= s1_y365_next;
        end
        if (adv2)
        begin
            s2_serial_reg <= s2_serial_next;
            s2_ok_reg     <= s2_ok_next;
        end
        if (adv3)
        begin
            s3_lo_reg  <= s3_lo_next;
            s3_hi_reg  <= s3_hi_next;
            s3_ovl_reg <= s3_ovl_next;
            s3_err_reg <= s3_err_next;
        end
        if (adv4)
        begin
            s4_reg <= s4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = s4_reg;

endmodule

`default_nettype wire

/* sv/dpod_checker.sv */
`default_nettype none

module dpod_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           in_valid,
    input wire logic           in_stall,
    input wire logic           out_valid,
    input wire logic           out_stall,
    input wire dpod_pkg::out_t out_data
);
    import dpod_pkg::*;

    // an invalid date leaves no count and no overlap
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.date_error |->
            out_data.overlap_days == '0 && !out_data.periods_overlap)
        else $error("date_error with non-zero result");

    a_disjoint_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.periods_overlap |-> out_data.overlap_days == '0)
        else $error("count without overlap");

    // back-pressure only reaches the input once the output is held
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // a stalled input transfer is still on offer in the next cycle
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("input withdrawn while stalled");

endmodule

bind date_period_overlap_days dpod_checker u_dpod_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
